### rtl/klat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// klat_pkg
// Shared types and constants of the oscillator lattice Euler stepper.
// ---------------------------------------------------------------------------
package klat_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int PHASE_BITS = 16;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(CELLS);
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int X_BITS     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_BITS     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DERIV_BITS = 20;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TIME_STEP   = 3'd2;
    localparam logic [2:0] REG_COUPLING    = 3'd3;
    localparam logic [2:0] REG_DAMPING     = 3'd4;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_WRITE,
        OP_STEP,
        OP_READ
    } t_op;

    typedef struct packed {
        logic [1:0]         kind;
        logic [13:0]        cell_index;
        logic [15:0]        phase_in;
        logic signed [15:0] natural_freq;
    } t_item;

    typedef struct packed {
        logic [15:0] phase_out;
        logic        step_done;
    } t_result;

    typedef struct packed {
        t_op                  op;
        logic [ADDR_BITS-1:0] idx;
        logic [15:0]          phase;
        logic signed [15:0]   freq;
    } t_cmd;

    typedef struct packed {
        logic [7:0]          width;
        logic [7:0]          height;
        logic [CNT_BITS-1:0] cells;
    } t_geom;

    typedef struct packed {
        logic [15:0]        dt;
        logic signed [15:0] coupling;
        logic signed [15:0] damping;
    } t_gains;

endpackage
`default_nettype wire

### rtl/klat_sine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// klat_sine
// Multi-cycle quarter-wave polynomial sine, one multiply per cycle.
// ---------------------------------------------------------------------------
module klat_sine (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire         [15:0] i_phase,
    output logic               o_valid,
    output logic signed [15:0] o_sine
);

    logic [2:0]  r_step;
    logic [1:0]  r_q;
    logic [14:0] r_z;
    logic [14:0] r_z2;
    logic [29:0] r_prod;
    logic        r_valid;
    logic signed [15:0] r_sine;

    logic [14:0] sh;
    logic [14:0] n_p;
    logic [14:0] mag;

    always_comb begin
        sh  = r_prod[28:14];
        n_p = 15'd0;
        unique case (r_step)
            3'd3:    n_p = 15'd1306 - sh;
            3'd4:    n_p = 15'd10584 - sh;
            3'd5:    n_p = 15'd25736 - sh;
            default: n_p = 15'd0;
        endcase
        mag = (r_prod[29:14] > 16'd16384) ? 15'd16384 : r_prod[28:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_step)
                3'd0: if (i_start) r_step <= 3'd1;
                3'd6: begin
                    r_valid <= 1'b1;
                    r_step  <= 3'd0;
                end
                default: r_step <= r_step + 3'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_step)
            3'd0: begin
                r_q <= i_phase[15:14];
                r_z <= i_phase[14] ? (15'd16384 - {1'b0, i_phase[13:0]})
                                   : {1'b0, i_phase[13:0]};
            end
            3'd1: r_prod <= r_z * r_z;
            3'd2: begin
                r_z2   <= sh;
                r_prod <= 15'd77 * sh;
            end
            3'd3, 3'd4: r_prod <= n_p * r_z2;
            3'd5: r_prod <= n_p * r_z;
            3'd6: r_sine <= r_q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            default: r_prod <= r_prod;
        endcase
    end

    assign o_valid = r_valid;
    assign o_sine  = r_sine;

endmodule
`default_nettype wire

### rtl/klat_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// klat_fifo
// Four-entry command queue between front and back.
// ---------------------------------------------------------------------------
module klat_fifo (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_wr,
    input  klat_pkg::t_cmd i_cmd,
    input  wire           i_rd,
    output logic          o_full,
    output logic          o_empty,
    output klat_pkg::t_cmd o_head
);

    klat_pkg::t_cmd r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (i_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_wr} - {2'd0, i_rd};
        end
    end

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_head  = r_mem[r_rp];

endmodule
`default_nettype wire

### rtl/klat_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// klat_front
// Accept items and classify them into commands, range-checking indexes.
// ---------------------------------------------------------------------------
module klat_front (
    input  wire                  i_push,
    input  klat_pkg::t_item      i_item,
    input  klat_pkg::t_geom      i_geom,
    input  wire                  i_q_full,
    output logic                 o_full,
    output logic                 o_wr,
    output klat_pkg::t_cmd       o_cmd
);

    logic in_grid;

    always_comb begin
        in_grid = ({1'b0, i_item.cell_index} < i_geom.cells);
        o_cmd.idx   = i_item.cell_index;
        o_cmd.phase = i_item.phase_in;
        o_cmd.freq  = i_item.natural_freq;
        unique case (i_item.kind)
            klat_pkg::KIND_WRITE: o_cmd.op = in_grid ? klat_pkg::OP_WRITE : klat_pkg::OP_NOP;
            klat_pkg::KIND_STEP:  o_cmd.op = klat_pkg::OP_STEP;
            klat_pkg::KIND_READ:  o_cmd.op = in_grid ? klat_pkg::OP_READ : klat_pkg::OP_NOP;
            default:              o_cmd.op = klat_pkg::OP_NOP;
        endcase
    end

    assign o_full = i_q_full;
    assign o_wr   = i_push && !i_q_full;

endmodule
`default_nettype wire

### rtl/klat_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// klat_back
// Execute commands: cell stores, two-pass Euler sweep, result hand-off.
// ---------------------------------------------------------------------------
module klat_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  klat_pkg::t_geom    i_geom,
    input  klat_pkg::t_gains   i_gains,
    input  wire                i_cmd_avail,
    input  klat_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_valid,
    input  wire                i_res_ready,
    output klat_pkg::t_result  o_res
);

    localparam int AB = klat_pkg::ADDR_BITS;
    localparam int CB = klat_pkg::CNT_BITS;
    localparam int XB = klat_pkg::X_BITS;
    localparam int YB = klat_pkg::Y_BITS;
    localparam int PB = klat_pkg::PHASE_BITS;
    localparam int DB = klat_pkg::DERIV_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RDC, S_P1_RD, S_P1_WT, S_P1_SN, S_P1_M1, S_P1_M2, S_P1_ACC,
        S_P2_RD, S_P2_MUL, S_P2_WR, S_RES
    } t_state;

    logic [PB-1:0]          phase_mem [klat_pkg::CELLS];
    logic [15:0]            freq_mem  [klat_pkg::CELLS];
    logic [DB-1:0]          deriv_mem [klat_pkg::CELLS];

    t_state                 r_state;
    logic [2:0]             r_k;
    logic [XB-1:0]          r_x;
    logic [YB-1:0]          r_y;
    logic [AB-1:0]          r_row;
    logic [AB-1:0]          r_i;
    logic [PB-1:0]          r_own;
    logic signed [15:0]     r_freq;
    logic signed [15:0]     r_sown;
    logic signed [16:0]     r_sum;
    logic signed [36:0]     r_mul;
    logic signed [36:0]     r_ka;
    logic [PB-1:0]          r_ph_rd;
    logic [15:0]            r_fq_rd;
    logic signed [DB-1:0]   r_dv_rd;
    klat_pkg::t_result      r_res;

    logic [CB-1:0]          w_ext;
    logic [CB-1:0]          x_ext;
    logic [CB-1:0]          cur;
    logic [CB-1:0]          xr;
    logic [CB-1:0]          xl;
    logic [CB-1:0]          up_base;
    logic [CB-1:0]          dn_base;
    logic [CB-1:0]          nb;
    logic                   x_last;
    logic                   y_last;
    logic [AB-1:0]          ph_raddr;
    logic                   ph_we;
    logic [AB-1:0]          ph_waddr;
    logic [PB-1:0]          ph_wdata;
    logic [PB-1:0]          sine_arg;
    logic                   sine_start;
    logic                   sine_valid;
    logic signed [15:0]     sine_val;
    logic signed [19:0]     mul_a;
    logic signed [16:0]     mul_b;
    logic signed [37:0]     acc;
    logic                   cmd_take;

    klat_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sine_start),
        .i_phase (sine_arg),
        .o_valid (sine_valid),
        .o_sine  (sine_val)
    );

    // neighbour addressing on the torus
    always_comb begin
        w_ext   = CB'(i_geom.width);
        x_ext   = CB'(r_x);
        cur     = CB'(r_row) + x_ext;
        x_last  = (CB'(r_x) + 1'b1 == w_ext);
        y_last  = (8'(r_y) + 8'd1 == i_geom.height);
        xr      = x_last ? '0 : x_ext + 1'b1;
        xl      = (r_x == '0) ? w_ext - 1'b1 : x_ext - 1'b1;
        up_base = y_last ? '0 : CB'(r_row) + w_ext;
        dn_base = (r_y == '0) ? i_geom.cells - w_ext : CB'(r_row) - w_ext;
        unique case (r_k)
            3'd1:    nb = CB'(r_row) + xr;
            3'd2:    nb = CB'(r_row) + xl;
            3'd3:    nb = up_base + x_ext;
            3'd4:    nb = dn_base + x_ext;
            default: nb = cur;
        endcase
    end

    always_comb begin
        cmd_take   = (r_state == S_IDLE) && i_cmd_avail;
        o_cmd_pop  = cmd_take;
        unique case (r_state)
            S_IDLE:  ph_raddr = i_cmd.idx;
            S_P1_RD: ph_raddr = nb[AB-1:0];
            S_P2_RD: ph_raddr = r_i;
            default: ph_raddr = cur[AB-1:0];
        endcase
        ph_we    = 1'b0;
        ph_waddr = i_cmd.idx;
        ph_wdata = i_cmd.phase[PB-1:0];
        if (cmd_take && i_cmd.op == klat_pkg::OP_WRITE) begin
            ph_we = 1'b1;
        end else if (r_state == S_P2_WR) begin
            ph_we    = 1'b1;
            ph_waddr = r_i;
            ph_wdata = r_own + r_mul[27:28-PB];
        end
        sine_start = (r_state == S_P1_WT);
        sine_arg   = (r_k == 3'd0) ? r_ph_rd : r_ph_rd - r_own;
        unique case (r_state)
            S_P1_M1: begin
                mul_a = 20'(r_sum);
                mul_b = 17'(i_gains.coupling);
            end
            S_P1_M2: begin
                mul_a = 20'(r_sown);
                mul_b = 17'(i_gains.damping);
            end
            default: begin
                mul_a = r_dv_rd;
                mul_b = $signed({1'b0, i_gains.dt});
            end
        endcase
        // freq*2^16 + K*S - 4*damping*sin(own); floor by 2^16 fits 18 bits,
        // so the 20-bit saturation never bites
        acc = {{6{r_freq[15]}}, r_freq, 16'd0} + {r_ka[36], r_ka}
            - {r_mul[35:0], 2'b00};
    end

    // cell stores, registered read
    always_ff @(posedge i_clk) begin
        if (ph_we) phase_mem[ph_waddr] <= ph_wdata;
        r_ph_rd <= phase_mem[ph_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take && i_cmd.op == klat_pkg::OP_WRITE) freq_mem[i_cmd.idx] <= i_cmd.freq;
        r_fq_rd <= freq_mem[cur[AB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_P1_ACC) deriv_mem[cur[AB-1:0]] <= acc[35:16];
        r_dv_rd <= deriv_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_P1_M1 || r_state == S_P1_M2 || r_state == S_P2_MUL) begin
            r_mul <= mul_a * mul_b;
        end
        if (r_state == S_P1_M2) r_ka <= r_mul;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 3'd0;
            r_x     <= '0;
            r_y     <= '0;
            r_row   <= '0;
            r_i     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_cmd_avail) begin
                    r_res <= '0;
                    unique case (i_cmd.op)
                        klat_pkg::OP_READ: r_state <= S_RDC;
                        klat_pkg::OP_STEP: begin
                            r_x     <= '0;
                            r_y     <= '0;
                            r_row   <= '0;
                            r_k     <= 3'd0;
                            r_sum   <= '0;
                            r_state <= S_P1_RD;
                        end
                        default: r_state <= S_RES;
                    endcase
                end
                S_RDC: begin
                    r_res.phase_out <= 16'(r_ph_rd);
                    r_state         <= S_RES;
                end
                S_P1_RD: r_state <= S_P1_WT;
                S_P1_WT: begin
                    if (r_k == 3'd0) begin
                        r_own  <= r_ph_rd;
                        r_freq <= r_fq_rd;
                    end
                    r_state <= S_P1_SN;
                end
                S_P1_SN: if (sine_valid) begin
                    if (r_k == 3'd0) r_sown <= sine_val;
                    else             r_sum  <= r_sum + 17'(sine_val);
                    if (r_k == 3'd4) begin
                        r_state <= S_P1_M1;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_P1_RD;
                    end
                end
                S_P1_M1: r_state <= S_P1_M2;
                S_P1_M2: r_state <= S_P1_ACC;
                S_P1_ACC: begin
                    r_k   <= 3'd0;
                    r_sum <= '0;
                    if (x_last) begin
                        r_x <= '0;
                        if (y_last) begin
                            r_i     <= '0;
                            r_state <= S_P2_RD;
                        end else begin
                            r_y     <= r_y + 1'b1;
                            r_row   <= r_row + AB'(i_geom.width);
                            r_state <= S_P1_RD;
                        end
                    end else begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_P1_RD;
                    end
                end
                S_P2_RD: r_state <= S_P2_MUL;
                S_P2_MUL: begin
                    r_own   <= r_ph_rd;
                    r_state <= S_P2_WR;
                end
                S_P2_WR: begin
                    if (CB'(r_i) + 1'b1 == i_geom.cells) begin
                        r_res.step_done <= 1'b1;
                        r_state         <= S_RES;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_P2_RD;
                    end
                end
                S_RES: if (i_res_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = (r_state == S_RES);
    assign o_res       = r_res;

endmodule
`default_nettype wire

### rtl/kuramoto_lattice_euler_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kuramoto_lattice_euler_step
// Toroidal lattice of phase oscillators advanced by explicit Euler steps.
// ---------------------------------------------------------------------------
// Usage: items enter through a queue-style port (i_push, o_full) and every
// item gives exactly one result on a queue-style port (o_empty, i_pop).
// Write items load one cell's phase and frequency, read items return its
// phase, step items advance the whole grid and answer with step_done set.
// A four-entry command queue parts the accepting front from the executing
// back, and a one-entry output register parts the back from the receiver,
// so items keep being taken while a result waits; a stalled receiver only
// stops the back once that register is full.
// A step walks the grid twice over one shared phase-store read port and one
// multi-cycle sine unit: a derivative pass (five reads and five sines per
// cell) and then an update pass.
// Reset (synchronous, active low) empties both queues, idles the sequencer
// and loads the register defaults; cell stores keep their contents and must
// be written before they are read. Configuration writes are always ready.
// ---------------------------------------------------------------------------
module kuramoto_lattice_euler_step (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_full,
    input  klat_pkg::t_item    i_item,
    output logic               o_empty,
    input  wire                i_pop,
    output klat_pkg::t_result  o_result,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [2:0]         i_cfg_index,
    input  wire  [15:0]        i_cfg_data
);

    logic [7:0]         r_grid_width;
    logic [7:0]         r_grid_height;
    logic [15:0]        r_time_step;
    logic [15:0]        r_coupling;
    logic [15:0]        r_damping;
    logic               r_out_valid;
    klat_pkg::t_result  r_out;

    klat_pkg::t_geom    geom;
    klat_pkg::t_gains   gains;
    logic [7:0]         ew;
    logic [7:0]         eh;
    logic               q_full;
    logic               q_empty;
    logic               q_wr;
    logic               q_rd;
    klat_pkg::t_cmd     q_in;
    klat_pkg::t_cmd     q_head;
    logic               res_valid;
    logic               res_ready;
    klat_pkg::t_result  res;

    // Register file: take writes whenever offered, drop unknown indexes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 8'd128;
            r_grid_height <= 8'd128;
            r_time_step   <= 16'd655;
            r_coupling    <= 16'd652;
            r_damping     <= 16'd65;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                klat_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[7:0];
                klat_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[7:0];
                klat_pkg::REG_TIME_STEP:   r_time_step   <= i_cfg_data;
                klat_pkg::REG_COUPLING:    r_coupling    <= i_cfg_data;
                klat_pkg::REG_DAMPING:     r_damping     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the grid to 1..max in each direction; a zero size acts as one.
    always_comb begin
        if (r_grid_width == 8'd0)                         ew = 8'd1;
        else if (32'(r_grid_width) > klat_pkg::MAX_WIDTH) ew = 8'(klat_pkg::MAX_WIDTH);
        else                                              ew = r_grid_width;
        if (r_grid_height == 8'd0)                          eh = 8'd1;
        else if (32'(r_grid_height) > klat_pkg::MAX_HEIGHT) eh = 8'(klat_pkg::MAX_HEIGHT);
        else                                                eh = r_grid_height;
        geom.width     = ew;
        geom.height    = eh;
        geom.cells     = klat_pkg::CNT_BITS'(ew) * klat_pkg::CNT_BITS'(eh);
        gains.dt       = r_time_step;
        gains.coupling = r_coupling;
        gains.damping  = r_damping;
    end

    klat_front u_front (
        .i_push   (i_push),
        .i_item   (i_item),
        .i_geom   (geom),
        .i_q_full (q_full),
        .o_full   (o_full),
        .o_wr     (q_wr),
        .o_cmd    (q_in)
    );

    klat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (q_in),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    klat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_gains     (gains),
        .i_cmd_avail (!q_empty),
        .i_cmd       (q_head),
        .o_cmd_pop   (q_rd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register: refill in the same cycle as the receiver drains it.
    assign res_ready = !r_out_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) r_out <= res;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // A step result never carries a phase.
    a_step_no_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.step_done |-> r_out.phase_out == 16'd0)
        else $error("step result carries a phase");

    // The back never hands over a result into an occupied, undrained slot.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && r_out_valid && !i_pop |=> $stable(r_out))
        else $error("waiting result overwritten");

    // The queue is never popped while empty.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_empty)
        else $error("command queue popped while empty");

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oscillator lattice Euler stepper: drives write,
// read, step and unknown items under several grid and gain settings, predicts
// every result in a scoreboard and compares each popped result field by field.
// ---------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int         STORE_DEPTH  = 16384;
    localparam int         IDLE_LIMIT   = 40000;
    localparam int         TOTAL_ITEMS  = 1050;

    // Scoreboard: mirror of the lattice state plus the queue of pending results.
    class lattice_scoreboard;
        logic [15:0] phase_mem [STORE_DEPTH];
        logic [15:0] freq_mem  [STORE_DEPTH];
        int unsigned width_reg, height_reg, dt_reg;
        int          coupling_reg, damping_reg;
        klat_pkg::t_result pending_q [$];
        int          errors;

        function new();
            width_reg    = 128;
            height_reg   = 128;
            dt_reg       = 655;
            coupling_reg = 652;
            damping_reg  = 65;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [15:0] data);
            case (index)
                klat_pkg::REG_GRID_WIDTH:  width_reg = data[7:0];
                klat_pkg::REG_GRID_HEIGHT: height_reg = data[7:0];
                klat_pkg::REG_TIME_STEP:   dt_reg = data;
                klat_pkg::REG_COUPLING:    coupling_reg = int'($signed(data));
                klat_pkg::REG_DAMPING:     damping_reg = int'($signed(data));
                default: ;
            endcase
        endfunction

        function int unsigned grid_w();
            return (width_reg == 0) ? 1 :
                   (width_reg > klat_pkg::MAX_WIDTH) ? klat_pkg::MAX_WIDTH : width_reg;
        endfunction

        function int unsigned grid_h();
            return (height_reg == 0) ? 1 :
                   (height_reg > klat_pkg::MAX_HEIGHT) ? klat_pkg::MAX_HEIGHT : height_reg;
        endfunction

        // Polynomial quarter-wave sine, signed Q1.14.
        function int turn_sine(logic [15:0] ph);
            int unsigned z, z2, p, s;
            z = ph[13:0];
            if (ph[14]) z = 16384 - z;
            z2 = (z * z) >> 14;
            p  = 1306 - ((77 * z2) >> 14);
            p  = 10584 - ((p * z2) >> 14);
            p  = 25736 - ((p * z2) >> 14);
            s  = (p * z) >> 14;
            if (s > 16384) s = 16384;
            return ph[15] ? -int'(s) : int'(s);
        endfunction

        // Derivatives from the old phases first, then advance every cell.
        function void euler_step();
            int unsigned w, h, x, y, xr, xl, yu, yd, c;
            longint      acc, d, inc;
            int          sum;
            logic [15:0] own;
            longint      deriv [];
            w = grid_w();
            h = grid_h();
            deriv = new[w * h];
            for (y = 0; y < h; y++) begin
                yu = (y + 1 == h) ? 0 : y + 1;
                yd = (y == 0) ? h - 1 : y - 1;
                for (x = 0; x < w; x++) begin
                    xr  = (x + 1 == w) ? 0 : x + 1;
                    xl  = (x == 0) ? w - 1 : x - 1;
                    c   = y * w + x;
                    own = phase_mem[c];
                    sum = turn_sine(phase_mem[y * w + xr] - own)
                        + turn_sine(phase_mem[y * w + xl] - own)
                        + turn_sine(phase_mem[yu * w + x] - own)
                        + turn_sine(phase_mem[yd * w + x] - own);
                    acc = longint'($signed(freq_mem[c])) * 65536
                        + longint'(coupling_reg) * sum
                        - 4 * longint'(damping_reg) * turn_sine(own);
                    d = acc >>> 16;
                    if (d > 524287) d = 524287;
                    if (d < -524288) d = -524288;
                    deriv[c] = d;
                end
            end
            for (c = 0; c < w * h; c++) begin
                inc = (deriv[c] * longint'(dt_reg)) >>> (28 - klat_pkg::PHASE_BITS);
                phase_mem[c] = phase_mem[c] + inc[15:0];
            end
        endfunction

        function void note_item(klat_pkg::t_item it);
            klat_pkg::t_result res;
            res = '0;
            case (it.kind)
                klat_pkg::KIND_WRITE: if (it.cell_index < grid_w() * grid_h()) begin
                    phase_mem[it.cell_index] = it.phase_in;
                    freq_mem[it.cell_index]  = it.natural_freq;
                end
                klat_pkg::KIND_STEP: begin
                    euler_step();
                    res.step_done = 1'b1;
                end
                klat_pkg::KIND_READ: if (it.cell_index < grid_w() * grid_h())
                    res.phase_out = phase_mem[it.cell_index];
                default: ;
            endcase
            pending_q.push_back(res);
        endfunction

        function void check_result(klat_pkg::t_result got);
            klat_pkg::t_result exp_res;
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing pending: phase %h done %b",
                         $realtime, got.phase_out, got.step_done);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (got.phase_out !== exp_res.phase_out) begin
                $display("%0t: phase_out mismatch, expected %h actual %h",
                         $realtime, exp_res.phase_out, got.phase_out);
                errors++;
            end
            if (got.step_done !== exp_res.step_done) begin
                $display("%0t: step_done mismatch, expected %b actual %b",
                         $realtime, exp_res.step_done, got.step_done);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_push;
    logic              o_full;
    klat_pkg::t_item   i_item;
    logic              o_empty;
    logic              i_pop;
    klat_pkg::t_result o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [15:0]       i_cfg_data;

    lattice_scoreboard lattice_sb;
    bit          cell_written [STORE_DEPTH];
    int unsigned send_idle_pct, recv_idle_pct;
    int unsigned recv_hold_cycles;
    int unsigned transactions;
    int unsigned items_sent;

    kuramoto_lattice_euler_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offer one item, idling at random first; called and returning at a falling edge.
    task automatic send_item(klat_pkg::t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_push = 1'b1;
        i_item = it;
        // hold the item until a rising edge sees the queue not full
        do @(posedge i_clk); while (o_full);
        lattice_sb.note_item(it);
        if (it.kind == klat_pkg::KIND_WRITE &&
            it.cell_index < lattice_sb.grid_w() * lattice_sb.grid_h())
            cell_written[it.cell_index] = 1'b1;
        transactions++;
        items_sent++;
        // move the idling pattern on by thirds of the run
        if (items_sent == TOTAL_ITEMS / 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 21;
        end else if (items_sent == 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
    endtask

    task automatic send_kind(logic [1:0] kind, int unsigned idx, int unsigned ph,
                             int unsigned fr);
        klat_pkg::t_item it;
        it.kind         = kind;
        it.cell_index   = idx[13:0];
        it.phase_in     = ph[15:0];
        it.natural_freq = fr[15:0];
        send_item(it);
    endtask

    // Drain outstanding results, let the block settle, then write one register.
    task automatic write_reg(logic [2:0] index, logic [15:0] data);
        i_push = 1'b0;
        while (lattice_sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        lattice_sb.write_reg(index, data);
        transactions++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random setting followed by a mix of items on that grid.
    task automatic run_phase(logic [7:0] w, logic [7:0] h, logic [15:0] dt,
                             logic [15:0] k, logic [15:0] dmp, int unsigned n_items);
        int unsigned cells, idx, roll, steps, i;
        write_reg(klat_pkg::REG_GRID_WIDTH, {8'd0, w});
        write_reg(klat_pkg::REG_GRID_HEIGHT, {8'd0, h});
        write_reg(klat_pkg::REG_TIME_STEP, dt);
        write_reg(klat_pkg::REG_COUPLING, k);
        write_reg(klat_pkg::REG_DAMPING, dmp);
        cells = lattice_sb.grid_w() * lattice_sb.grid_h();
        steps = 0;
        // load every cell that a sweep will touch
        for (idx = 0; idx < cells; idx++)
            if (!cell_written[idx])
                send_kind(klat_pkg::KIND_WRITE, idx, $urandom, $urandom);
        for (i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, cells - 1);
            if (roll < 35)
                send_kind(klat_pkg::KIND_WRITE, idx, $urandom, $urandom);
            else if (roll < 43 && cells < STORE_DEPTH)
                send_kind(klat_pkg::KIND_WRITE, $urandom_range(cells, STORE_DEPTH - 1),
                          $urandom, $urandom);
            else if (roll < 70)
                send_kind(klat_pkg::KIND_READ, idx, $urandom, $urandom);
            else if (roll < 78 && cells < STORE_DEPTH)
                send_kind(klat_pkg::KIND_READ, $urandom_range(cells, STORE_DEPTH - 1),
                          $urandom, $urandom);
            else if (roll < 95 && (cells <= 64 || steps < 2)) begin
                send_kind(klat_pkg::KIND_STEP, $urandom, $urandom, $urandom);
                steps++;
            end else
                send_kind(KIND_UNKNOWN, $urandom, $urandom, $urandom);
        end
    endtask

    // Receiver: pop at random, hold off when asked, check every transaction.
    initial begin
        forever begin
            @(negedge i_clk);
            if (recv_hold_cycles != 0) begin
                i_pop = 1'b0;
                recv_hold_cycles--;
            end else begin
                i_pop = ($urandom_range(0, 99) >= recv_idle_pct);
            end
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                lattice_sb.check_result(o_result);
                transactions++;
            end
        end
    end

    // Watchdog: end the run if no transaction completes for too long.
    initial begin
        int unsigned last_seen, quiet;
        last_seen = 0;
        quiet     = 0;
        forever begin
            @(posedge i_clk);
            if (transactions != last_seen) begin
                last_seen = transactions;
                quiet     = 0;
            end else begin
                quiet++;
            end
            if (quiet >= IDLE_LIMIT) begin
                $display("kuramoto_lattice_euler_step test failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned i;
        lattice_sb       = new();
        i_rst_n          = 1'b0;
        i_push           = 1'b0;
        i_pop            = 1'b0;
        i_item           = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        send_idle_pct    = 21;
        recv_idle_pct    = 46;
        recv_hold_cycles = 0;
        transactions     = 0;
        items_sent       = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset geometry: extreme corners and field values.
        send_kind(klat_pkg::KIND_WRITE, 0, 16'h0000, 16'h8000);
        send_kind(klat_pkg::KIND_WRITE, STORE_DEPTH - 1, 16'hFFFF, 16'h7FFF);
        send_kind(klat_pkg::KIND_READ, 0, 16'hFFFF, 16'hFFFF);
        send_kind(klat_pkg::KIND_READ, STORE_DEPTH - 1, 16'h0000, 16'h0000);
        send_kind(KIND_UNKNOWN, STORE_DEPTH - 1, 16'hFFFF, 16'hFFFF);
        // hold the receiver off while writes keep coming, to fill the block
        recv_hold_cycles = 300;
        for (i = 1; i <= 16; i++)
            send_kind(klat_pkg::KIND_WRITE, i, $urandom, $urandom);
        send_kind(klat_pkg::KIND_READ, 5, 16'h0000, 16'h0000);

        // Directed settings: zero-size grid, oversized width and height, gain extremes.
        run_phase(8'd0, 8'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 20);
        run_phase(8'd255, 8'd1, 16'h0000, 16'h7FFF, 16'h8000, 40);
        run_phase(8'd1, 8'd255, 16'hFFFF, 16'h7FFF, 16'h7FFF, 40);
        run_phase(8'd4, 8'd4, 16'd655, 16'd652, 16'd65, 60);

        // Random settings on small grids.
        while (items_sent < TOTAL_ITEMS)
            run_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                      16'($urandom), 16'($urandom), 16'($urandom), 110);

        i_push = 1'b0;
        while (lattice_sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (lattice_sb.errors == 0)
            $display("kuramoto_lattice_euler_step test passed");
        else
            $display("kuramoto_lattice_euler_step test failed");
        $finish;
    end

endmodule
